/* src/tpsc_pkg.sv */
// Package for the three-phase sine commutator.
// Holds the quarter-wave offset-sine table and the fixed constants.
// Has no dependencies.
package tpsc_pkg;

    // Quarter-wave table geometry.
    localparam int ROM_DEPTH = 225;
    localparam int ROM_LAST  = ROM_DEPTH - 1;

    // Full-scale duty, used to mirror the lower half wave.
    localparam logic [7:0] DUTY_MAX = 8'd255;

    // Offset that turns a signed 8-bit step into an unsigned 0 to 255 value.
    localparam int STEP_OFFSET = 128;

    // Fraction bits of the reciprocal used for the step remainder.
    localparam int RECIP_SHIFT = 16;

    // Entries of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Quarter-wave offset sine, values 128 to 255.
    localparam logic [7:0] QUARTER_ROM [ROM_DEPTH] = '{
        8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd132, 8'd133, 8'd134,
        8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd139, 8'd140, 8'd141,
        8'd142, 8'd143, 8'd144, 8'd145, 8'd146, 8'd147, 8'd147, 8'd148,
        8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd154, 8'd155,
        8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
        8'd163, 8'd164, 8'd165, 8'd166, 8'd166, 8'd167, 8'd168, 8'd169,
        8'd170, 8'd171, 8'd172, 8'd172, 8'd173, 8'd174, 8'd175, 8'd176,
        8'd176, 8'd177, 8'd178, 8'd179, 8'd180, 8'd181, 8'd181, 8'd182,
        8'd183, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189,
        8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193, 8'd194, 8'd195,
        8'd195, 8'd196, 8'd197, 8'd198, 8'd198, 8'd199, 8'd200, 8'd201,
        8'd201, 8'd202, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206,
        8'd207, 8'd208, 8'd208, 8'd209, 8'd210, 8'd210, 8'd211, 8'd212,
        8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd216, 8'd216, 8'd217,
        8'd218, 8'd218, 8'd219, 8'd220, 8'd220, 8'd221, 8'd221, 8'd222,
        8'd223, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225, 8'd226, 8'd227,
        8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd230, 8'd231,
        8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd235,
        8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239,
        8'd239, 8'd239, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242,
        8'd242, 8'd243, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
        8'd245, 8'd246, 8'd246, 8'd246, 8'd247, 8'd247, 8'd247, 8'd247,
        8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd249, 8'd250,
        8'd250, 8'd250, 8'd250, 8'd251, 8'd251, 8'd251, 8'd251, 8'd252,
        8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
        8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255
    };

endpackage

/* src/tpsc_front.sv */
// Front end of the commutator: accepts requests and reduces the signed
// step to its remainder modulo the table length. Uses tpsc_pkg.
module tpsc_front #(
    parameter int TABLE_LENGTH = 900
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [7:0]                 step_segments,
    input  logic [2:0]                        amplitude_shift,
    output logic                              push_valid,
    input  logic                              push_stall,
    output logic [$clog2(TABLE_LENGTH)+2:0]   push_data
);
    import tpsc_pkg::*;

    localparam int ANGLE_W = $clog2(TABLE_LENGTH);
    localparam logic [15:0] RECIP    = 16'((1 << RECIP_SHIFT) / TABLE_LENGTH);
    localparam logic [15:0] LEN16    = 16'(TABLE_LENGTH);
    localparam logic [15:0] OFS_REM  = 16'(STEP_OFFSET % TABLE_LENGTH);

    logic       valid_reg, valid_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] quot_reg, quot_next;
    logic [2:0] shift_reg, shift_next;
    logic       load;
    logic [23:0] prod;
    logic [15:0] rem_raw, rem_fix, adj_raw, adj_fix;

    // The stage takes a new request when empty or when its item leaves.
    assign load     = !valid_reg || !push_stall;
    assign in_stall = !load;

    // Offset the step to unsigned and estimate the quotient by reciprocal.
    always_comb
    begin
        x_next     = {~step_segments[7], step_segments[6:0]};
        prod       = 24'(x_next) * 24'(RECIP);
        quot_next  = prod[23:16];
        shift_next = amplitude_shift;
        valid_next = load ? in_valid : valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            x_reg     <= x_next;
            quot_reg  <= quot_next;
            shift_reg <= shift_next;
        end
    end

    // Finish the remainder: the estimate is low by at most one, then
    // remove the offset again so the result is the step modulo the length.
    always_comb
    begin
        rem_raw = 16'(x_reg) - (16'(quot_reg) * LEN16);
        rem_fix = (rem_raw >= LEN16) ? (rem_raw - LEN16) : rem_raw;
        adj_raw = rem_fix + LEN16 - OFS_REM;
        adj_fix = (adj_raw >= LEN16) ? (adj_raw - LEN16) : adj_raw;
    end

    assign push_valid = valid_reg;
    assign push_data  = {ANGLE_W'(adj_fix), shift_reg};

endmodule

/* src/tpsc_queue.sv */
// Short register queue that decouples the front from the back.
// Uses tpsc_pkg for its depth.
module tpsc_queue #(
    parameter int WIDTH = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);
    import tpsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/tpsc_back.sv */
// Back end of the commutator: advances the field angle and looks up the
// three phase duties in the quarter-wave table. Uses tpsc_pkg.
module tpsc_back #(
    parameter int TABLE_LENGTH = 900
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_stall,
    input  logic [$clog2(TABLE_LENGTH)+2:0]  pop_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       duty_a,
    output logic [7:0]                       duty_b,
    output logic [7:0]                       duty_c,
    output logic [$clog2(TABLE_LENGTH)-1:0]  field_angle
);
    import tpsc_pkg::*;

    localparam int ANGLE_W = $clog2(TABLE_LENGTH);
    localparam logic [ANGLE_W:0]   LEN_EXT   = (ANGLE_W + 1)'(TABLE_LENGTH);
    localparam logic [ANGLE_W:0]   THIRD_EXT = (ANGLE_W + 1)'(TABLE_LENGTH / 3);
    localparam logic [ANGLE_W:0]   TWO_THIRD = (ANGLE_W + 1)'(2 * (TABLE_LENGTH / 3));
    localparam logic [ANGLE_W-1:0] Q1_SEG    = ANGLE_W'(TABLE_LENGTH / 4);
    localparam logic [ANGLE_W-1:0] Q2_SEG    = ANGLE_W'(TABLE_LENGTH * 2 / 4);
    localparam logic [ANGLE_W-1:0] Q3_SEG    = ANGLE_W'(TABLE_LENGTH * 3 / 4);
    localparam logic [ANGLE_W-1:0] LAST_SEG  = ANGLE_W'(TABLE_LENGTH - 1);
    localparam logic [ANGLE_W-1:0] HALF_SEG  = ANGLE_W'(TABLE_LENGTH / 2);
    localparam logic [ANGLE_W-1:0] HALF_M1   = ANGLE_W'(TABLE_LENGTH / 2 - 1);

    // Duty at one segment through quarter-wave symmetry.
    function automatic logic [7:0] sine_at(input logic [ANGLE_W-1:0] s);
        logic [ANGLE_W-1:0] idx;
        logic               flip;
        logic [7:0]         ri;
        logic [7:0]         v;
        if (s >= Q3_SEG)
        begin
            idx  = LAST_SEG - s;
            flip = 1'b1;
        end
        else if (s >= Q2_SEG)
        begin
            idx  = s - HALF_SEG;
            flip = 1'b1;
        end
        else if (s >= Q1_SEG)
        begin
            idx  = HALF_M1 - s;
            flip = 1'b0;
        end
        else
        begin
            idx  = s;
            flip = 1'b0;
        end
        // Odd table lengths could reach past the last entry; hold it there.
        ri = (32'(idx) > ROM_LAST) ? 8'(ROM_LAST) : 8'(idx);
        v  = QUARTER_ROM[ri];
        return flip ? (DUTY_MAX - v) : v;
    endfunction

    logic               angle_valid_reg, angle_valid_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [2:0]         shift_reg;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         duty_a_reg, duty_b_reg, duty_c_reg;
    logic [7:0]         duty_a_next, duty_b_next, duty_c_next;
    logic               out_load, angle_adv, take;
    logic [ANGLE_W-1:0] step_mod;
    logic [2:0]         step_shift;
    logic [ANGLE_W:0]   sum, seg_b_sum, seg_a_sum;
    logic [ANGLE_W-1:0] seg_a, seg_b;

    assign step_mod   = pop_data[ANGLE_W+2:3];
    assign step_shift = pop_data[2:0];

    // Handshake between the angle stage and the output register.
    assign out_load  = !out_valid_reg || !out_stall;
    assign angle_adv = !angle_valid_reg || out_load;
    assign take      = pop_valid && angle_adv;
    assign pop_stall = !angle_adv;

    // Angle update: the step is already reduced, so one wrap is enough.
    always_comb
    begin
        sum              = {1'b0, angle_reg} + {1'b0, step_mod};
        angle_next       = (sum >= LEN_EXT) ? ANGLE_W'(sum - LEN_EXT) : ANGLE_W'(sum);
        angle_valid_next = angle_adv ? pop_valid : angle_valid_reg;
    end

    // Phase segments and duty lookups from the registered angle.
    always_comb
    begin
        seg_b_sum      = {1'b0, angle_reg} + THIRD_EXT;
        seg_a_sum      = {1'b0, angle_reg} + TWO_THIRD;
        seg_b          = (seg_b_sum >= LEN_EXT) ? ANGLE_W'(seg_b_sum - LEN_EXT)
                                                : ANGLE_W'(seg_b_sum);
        seg_a          = (seg_a_sum >= LEN_EXT) ? ANGLE_W'(seg_a_sum - LEN_EXT)
                                                : ANGLE_W'(seg_a_sum);
        duty_a_next    = sine_at(seg_a) >> shift_reg;
        duty_b_next    = sine_at(seg_b) >> shift_reg;
        duty_c_next    = sine_at(angle_reg) >> shift_reg;
        out_valid_next = out_load ? angle_valid_reg : out_valid_reg;
    end

    // Control state, including the field angle itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid_reg <= 1'b0;
            angle_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            angle_valid_reg <= angle_valid_next;
            out_valid_reg   <= out_valid_next;
            if (take)
            begin
                angle_reg <= angle_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            shift_reg <= step_shift;
        end
        if (out_load && angle_valid_reg)
        begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty_a      = duty_a_reg;
    assign duty_b      = duty_b_reg;
    assign duty_c      = duty_c_reg;
    assign field_angle = angle_reg;

endmodule

/* src/three_phase_sine_commutator.sv */
// Top level of the three-phase sine commutator.
// Connects tpsc_front, tpsc_queue and tpsc_back; uses tpsc_pkg.
//
//   Channel  Signals                              Direction  Content
//   in       in_valid, in_stall                   into block step_segments, amplitude_shift
//   out      out_valid, out_stall                 out of blk duty_a, duty_b, duty_c
//
// While the output is not stalled, one request is taken per cycle and one result is given per cycle.
// A result passes, in order, the front remainder stage, the two-entry queue,
// the angle register and the output register.
// The field angle register is the only loop in the datapath.
// Reset clears the angle to zero and empties every stage.
// A stall on the output fills the queue before the input stall rises.
module three_phase_sine_commutator #(
    parameter int TABLE_LENGTH = 900
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [7:0] step_segments,
    input  logic [2:0]        amplitude_shift,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        duty_a,
    output logic [7:0]        duty_b,
    output logic [7:0]        duty_c
);
    import tpsc_pkg::*;

    localparam int ANGLE_W = $clog2(TABLE_LENGTH);
    localparam int ITEM_W  = ANGLE_W + 3;

    logic              push_valid, push_stall;
    logic [ITEM_W-1:0] push_data;
    logic              pop_valid, pop_stall;
    logic [ITEM_W-1:0] pop_data;
    logic [ANGLE_W-1:0] field_angle;

    tpsc_front #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .step_segments   (step_segments),
        .amplitude_shift (amplitude_shift),
        .push_valid      (push_valid),
        .push_stall      (push_stall),
        .push_data       (push_data)
    );

    tpsc_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data)
    );

    tpsc_back #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_stall   (pop_stall),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .field_angle (field_angle)
    );

    // The field angle always stays inside the table.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(field_angle) < TABLE_LENGTH))
        else $error("field angle left the table range");

    // The angle moves only when the back takes an item from the queue.
    a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop_valid && !pop_stall) |=> $stable(field_angle))
        else $error("field angle changed without a queued step");

    // The front stalls the input only while the queue is full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (push_valid && push_stall))
        else $error("input stalled while the queue had room");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the three-phase sine commutator.
// Drives signed steps and amplitude shifts, predicts the three phase duties
// and checks every result. Depends on tpsc_pkg and three_phase_sine_commutator.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tpsc_pkg::*;

    localparam int TABLE_LENGTH = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] duty_c;
    } duty_triplet_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic signed [7:0] step_segments;
    logic [2:0]        amplitude_shift;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        duty_a;
    logic [7:0]        duty_b;
    logic [7:0]        duty_c;

    // Predicted duties waiting for the block, oldest first.
    duty_triplet_t pending_duties[$];

    // Predictor copy of the field angle.
    int model_angle;

    int  mismatch_count;
    int  cycle_count;
    bit  idling_on;
    int  hold_request;
    int  hold_left;
    int  stall_burst;

    three_phase_sine_commutator #(
        .TABLE_LENGTH(TABLE_LENGTH)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .step_segments   (step_segments),
        .amplitude_shift (amplitude_shift),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .duty_a          (duty_a),
        .duty_b          (duty_b),
        .duty_c          (duty_c)
    );

    // Clock, 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Quarter-table read with the index held inside the table.
    function automatic int quarter_at(input int idx);
        if (idx < 0)
        begin
            idx = 0;
        end
        if (idx > ROM_LAST)
        begin
            idx = ROM_LAST;
        end
        return int'(QUARTER_ROM[idx]);
    endfunction

    // Offset sine at one segment, built from the quarter table by symmetry.
    function automatic int offset_sine(input int seg);
        if (seg >= TABLE_LENGTH * 3 / 4)
        begin
            return 255 - quarter_at(TABLE_LENGTH - seg - 1);
        end
        if (seg >= TABLE_LENGTH * 2 / 4)
        begin
            return 255 - quarter_at(seg - TABLE_LENGTH / 2);
        end
        if (seg >= TABLE_LENGTH / 4)
        begin
            return quarter_at(TABLE_LENGTH / 2 - seg - 1);
        end
        return quarter_at(seg);
    endfunction

    // Advances the predicted angle and returns the three shifted duties.
    function automatic duty_triplet_t commutate(input logic signed [7:0] step,
                                                input logic [2:0] shift);
        duty_triplet_t duties;
        int next_angle;
        int seg;
        next_angle = (model_angle + int'(step)) % TABLE_LENGTH;
        if (next_angle < 0)
        begin
            next_angle += TABLE_LENGTH;
        end
        model_angle = next_angle;
        seg = next_angle;
        duties.duty_c = 8'(offset_sine(seg) >> shift);
        seg += TABLE_LENGTH / 3;
        if (seg >= TABLE_LENGTH)
        begin
            seg -= TABLE_LENGTH;
        end
        duties.duty_b = 8'(offset_sine(seg) >> shift);
        seg += TABLE_LENGTH / 3;
        if (seg >= TABLE_LENGTH)
        begin
            seg -= TABLE_LENGTH;
        end
        duties.duty_a = 8'(offset_sine(seg) >> shift);
        return duties;
    endfunction

    // Offers one request and waits until the block takes it.
    task automatic send_step(input logic signed [7:0] step, input logic [2:0] shift);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        = 1'b1;
        step_segments   = step;
        amplitude_shift = shift;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_duties.push_back(commutate(step, shift));
    endtask

    // Sends a random step; mostly the small steps of normal running.
    task automatic send_random_step();
        logic signed [7:0] step;
        if ($urandom_range(0, 3) == 0)
        begin
            step = 8'($urandom_range(0, 255));
        end
        else
        begin
            step = 8'(int'($urandom_range(0, 16)) - 8);
        end
        send_step(step, 3'($urandom_range(0, 7)));
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_duties.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Wraps in both directions and every quadrant boundary, all shifts.
    task automatic test_directed_corners();
        logic signed [7:0] steps[17] = '{
            8'sd0, -8'sd1, 8'sd1, 8'sd127, 8'sd97, 8'sd1, 8'sd127, 8'sd97, 8'sd1,
            8'sd127, 8'sd97, 8'sd1, 8'sd127, 8'sd97, 8'sd1, -8'sd128, -8'sd128
        };
        for (int i = 0; i < 17; i++)
        begin
            send_step(steps[i], 3'(i % 8));
        end
        send_step(8'sd0, 3'd7);
    endtask

    // Random steps and shifts with random idling on both sides.
    task automatic test_random_steps(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_random_step();
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure(input int count);
        hold_request = 48;
        for (int i = 0; i < count; i++)
        begin
            send_random_step();
        end
    endtask

    // The sender pauses until the block has delivered every result.
    task automatic test_drain_pause(input int count);
        test_random_steps(count);
        wait_for_drain();
        test_random_steps(count);
    endtask

    // Back-to-back requests with no idling on either side.
    task automatic test_full_rate(input int count);
        idling_on = 1'b0;
        test_random_steps(count);
    endtask

    // Receiver stall: long holds on request, otherwise short random bursts.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (stall_burst > 0)
        begin
            out_stall = 1'b1;
            stall_burst--;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            out_stall   = 1'b1;
            stall_burst = $urandom_range(1, 4) - 1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge clk)
    begin
        duty_triplet_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_duties.size() == 0)
            begin
                $error("result with no request pending: duty_a %0d duty_b %0d duty_c %0d",
                       duty_a, duty_b, duty_c);
                mismatch_count++;
            end
            else
            begin
                want = pending_duties.pop_front();
                if (duty_a !== want.duty_a)
                begin
                    $error("duty_a: expected %0d, actual %0d", want.duty_a, duty_a);
                    mismatch_count++;
                end
                if (duty_b !== want.duty_b)
                begin
                    $error("duty_b: expected %0d, actual %0d", want.duty_b, duty_b);
                    mismatch_count++;
                end
                if (duty_c !== want.duty_c)
                begin
                    $error("duty_c: expected %0d, actual %0d", want.duty_c, duty_c);
                    mismatch_count++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** three_phase_sine_commutator: FAILED **");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        out_stall       = 1'b0;
        step_segments   = '0;
        amplitude_shift = '0;
        model_angle     = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        idling_on       = 1'b1;
        hold_request    = 0;
        hold_left       = 0;
        stall_burst     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_random_steps(600);
        test_output_backpressure(80);
        test_drain_pause(10);
        test_full_rate(140);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_duties.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_duties.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("** three_phase_sine_commutator: PASSED **");
        end
        else
        begin
            $display("** three_phase_sine_commutator: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
src/tpsc_pkg.sv
src/tpsc_front.sv
src/tpsc_queue.sv
src/tpsc_back.sv
src/three_phase_sine_commutator.sv
tb/sv/tb_top.sv
